// ===== design/imhpq_pkg.sv =====
`default_nettype none
package imhpq_pkg;

  localparam int NODE_W = 10;
  localparam int CNT_W  = 11;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_POP    = 2'd1,
    MODE_DECR   = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_QUEUED = 3'd3,
    ST_NOT_SMALLER = 3'd4,
    ST_RANGE      = 3'd5
  } status_t;

  localparam logic REG_NODE_COUNT = 1'b0;

endpackage
`default_nettype wire

// ===== design/imhpq_if.sv =====
`default_nettype none
interface imhpq_req_if #(parameter int WEIGHT_BITS = 32);
  import imhpq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [NODE_W-1:0]      node;
  logic [WEIGHT_BITS-1:0] weight;
  modport source (output valid, mode, node, weight, input ready);
  modport sink (input valid, mode, node, weight, output ready);
endinterface

interface imhpq_rsp_if #(parameter int WEIGHT_BITS = 32);
  import imhpq_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [2:0]             status;
  logic [NODE_W-1:0]      out_node;
  logic [WEIGHT_BITS-1:0] priority_res;
  logic                   queued;
  logic [CNT_W-1:0]       entry_count;
  modport source (output valid, status, out_node, priority_res, queued, entry_count,
                  input ready);
  modport sink (input valid, status, out_node, priority_res, queued, entry_count,
                output ready);
endinterface
`default_nettype wire

// ===== design/imhpq_ram.sv =====
`default_nettype none
module imhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/indexed_min_heap_priority_queue_top.sv =====
`default_nettype none
// Indexed binary min-heap of node ids with insert, pop-minimum, decrease-key and
// lookup, one result item for every request item. Priorities, heap slots and the
// slot of each node sit in synchronous RAMs; a sequencer sifts one heap level per
// cycle, moving the displaced entry and writing the sifted entry once at its final
// slot. After reset a clearing pass sets every priority to all ones before the first
// item is taken.
module indexed_min_heap_priority_queue_top #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready,
  imhpq_req_if.sink                req,
  imhpq_rsp_if.source              rsp
);
  import imhpq_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int SW = $clog2(MAX_NODES + 1);
  localparam int HW = NODE_W + WEIGHT_BITS;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_LOOK = 7'b0000100,
    S_POP  = 7'b0001000,
    S_UP   = 7'b0010000,
    S_DN   = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] clr_cnt, clr_cnt_next;
  logic [SW-1:0] fill, fill_next;
  logic [CNT_W-1:0] node_count;
  logic [1:0] mode_r, mode_r_next;
  logic [NODE_W-1:0] node_r, node_r_next;
  logic [WEIGHT_BITS-1:0] w_r, w_r_next;
  logic [NODE_W-1:0] m_node, m_node_next;
  logic [WEIGHT_BITS-1:0] m_w, m_w_next;
  logic [SW-1:0] slot, slot_next;
  status_t res_status, res_status_next;
  logic [NODE_W-1:0] res_node, res_node_next;
  logic [WEIGHT_BITS-1:0] res_prio, res_prio_next;
  logic res_q, res_q_next;

  logic o_valid;
  logic [2:0] o_status;
  logic [NODE_W-1:0] o_node;
  logic [WEIGHT_BITS-1:0] o_prio;
  logic o_q;
  logic [CNT_W-1:0] o_cnt;

  logic pr_we;
  logic [AW-1:0] pr_waddr, pr_raddr;
  logic [WEIGHT_BITS-1:0] pr_wdata, pr_rdata;
  logic ps_we;
  logic [AW-1:0] ps_waddr, ps_raddr;
  logic [SW-1:0] ps_wdata, ps_rdata;
  logic hp_we;
  logic [AW-1:0] hp_waddr, ha_raddr, hb_raddr;
  logic [HW-1:0] hp_wdata, ha_rdata, hb_rdata;

  logic in_acc, in_range;
  logic [NODE_W-1:0] ha_node, hb_node;
  logic [WEIGHT_BITS-1:0] ha_w, hb_w;
  logic [SW:0] l_slot, r_slot;
  logic has_l, has_r, go_dn, pick_r;
  logic [SW-1:0] cs, ins_slot;
  logic [SW+1:0] cs2;

  imhpq_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES)) u_prio (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );
  imhpq_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_pos (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .raddr(ps_raddr), .rdata(ps_rdata)
  );
  imhpq_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_heap_a (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(ha_raddr), .rdata(ha_rdata)
  );
  imhpq_ram #(.WIDTH(HW), .DEPTH(MAX_NODES)) u_heap_b (
    .clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
    .raddr(hb_raddr), .rdata(hb_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? {{(32 - CNT_W){1'b0}}, node_count} : 32'd0;

  assign req.ready = (state == S_IDLE);
  assign in_acc = req.valid && (state == S_IDLE);
  assign in_range = ({1'b0, req.node} < node_count) && (32'(req.node) < MAX_NODES);

  assign ha_node = ha_rdata[HW-1:WEIGHT_BITS];
  assign ha_w = ha_rdata[WEIGHT_BITS-1:0];
  assign hb_node = hb_rdata[HW-1:WEIGHT_BITS];
  assign hb_w = hb_rdata[WEIGHT_BITS-1:0];

  assign l_slot = {slot, 1'b0};
  assign r_slot = {slot, 1'b1};
  assign has_l = l_slot <= (SW + 1)'(fill);
  assign has_r = r_slot <= (SW + 1)'(fill);
  assign ins_slot = fill + SW'(1);

  always_comb begin
    go_dn = 1'b0;
    pick_r = 1'b0;
    if (has_r) begin
      if ((ha_w < m_w) || (hb_w < m_w)) begin
        go_dn = 1'b1;
        pick_r = !(ha_w < hb_w);
      end
    end else if (has_l) begin
      go_dn = ha_w < m_w;
    end
    cs = pick_r ? SW'(r_slot) : SW'(l_slot);
    cs2 = {1'b0, cs, 1'b0};
  end

  always_comb begin
    state_next = state;
    clr_cnt_next = clr_cnt;
    fill_next = fill;
    mode_r_next = mode_r;
    node_r_next = node_r;
    w_r_next = w_r;
    m_node_next = m_node;
    m_w_next = m_w;
    slot_next = slot;
    res_status_next = res_status;
    res_node_next = res_node;
    res_prio_next = res_prio;
    res_q_next = res_q;
    pr_we = 1'b0;
    pr_waddr = AW'(node_r);
    pr_wdata = w_r;
    pr_raddr = AW'(req.node);
    ps_we = 1'b0;
    ps_waddr = AW'(m_node);
    ps_wdata = slot;
    ps_raddr = AW'(req.node);
    hp_we = 1'b0;
    hp_waddr = AW'(slot - SW'(1));
    hp_wdata = {m_node, m_w};
    ha_raddr = AW'((slot >> 1) - SW'(1));
    hb_raddr = AW'(fill - SW'(1));

    case (state)
      S_CLR: begin
        pr_we = 1'b1;
        pr_waddr = clr_cnt;
        pr_wdata = '1;
        ps_we = 1'b1;
        ps_waddr = clr_cnt;
        ps_wdata = '0;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(MAX_NODES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_r_next = req.mode;
          node_r_next = req.node;
          w_r_next = req.weight;
          res_node_next = req.node;
          res_prio_next = '0;
          res_q_next = 1'b0;
          res_status_next = ST_OK;
          if (req.mode == MODE_POP) begin
            if (fill == '0) begin
              res_status_next = ST_EMPTY;
              res_node_next = '0;
              state_next = S_FIN;
            end else begin
              ha_raddr = '0;
              hb_raddr = AW'(fill - SW'(1));
              state_next = S_POP;
            end
          end else if (!in_range) begin
            res_status_next = ST_RANGE;
            state_next = S_FIN;
          end else begin
            state_next = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        res_status_next = ST_OK;
        res_prio_next = pr_rdata;
        res_q_next = ps_rdata != '0;
        state_next = S_FIN;
        case (mode_r)
          MODE_INSERT: begin
            if (ps_rdata != '0) begin
              res_status_next = ST_QUEUED;
            end else begin
              pr_we = 1'b1;
              fill_next = ins_slot;
              slot_next = ins_slot;
              m_node_next = node_r;
              m_w_next = w_r;
              res_prio_next = w_r;
              res_q_next = 1'b1;
              ha_raddr = AW'((ins_slot >> 1) - SW'(1));
              state_next = S_UP;
            end
          end
          MODE_DECR: begin
            if (ps_rdata == '0) begin
              res_status_next = ST_NOT_QUEUED;
            end else if (!(w_r < pr_rdata)) begin
              res_status_next = ST_NOT_SMALLER;
            end else begin
              pr_we = 1'b1;
              slot_next = ps_rdata;
              m_node_next = node_r;
              m_w_next = w_r;
              res_prio_next = w_r;
              ha_raddr = AW'((ps_rdata >> 1) - SW'(1));
              state_next = S_UP;
            end
          end
          default: begin
          end
        endcase
      end
      S_UP: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if ((slot > SW'(1)) && (m_w < ha_w)) begin
          hp_wdata = ha_rdata;
          ps_waddr = AW'(ha_node);
          slot_next = slot >> 1;
          ha_raddr = AW'((slot >> 2) - SW'(1));
        end else begin
          state_next = S_FIN;
        end
      end
      S_POP: begin
        res_node_next = ha_node;
        res_prio_next = ha_w;
        res_q_next = 1'b0;
        ps_we = 1'b1;
        ps_waddr = AW'(ha_node);
        ps_wdata = '0;
        fill_next = fill - SW'(1);
        if (fill == SW'(1)) begin
          state_next = S_FIN;
        end else begin
          m_node_next = hb_node;
          m_w_next = hb_w;
          slot_next = SW'(1);
          ha_raddr = AW'(1);
          hb_raddr = AW'(2);
          state_next = S_DN;
        end
      end
      S_DN: begin
        hp_we = 1'b1;
        ps_we = 1'b1;
        if (go_dn) begin
          hp_wdata = pick_r ? hb_rdata : ha_rdata;
          ps_waddr = pick_r ? AW'(hb_node) : AW'(ha_node);
          slot_next = cs;
          ha_raddr = AW'(cs2 - (SW + 2)'(1));
          hb_raddr = AW'(cs2);
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!o_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      fill <= '0;
      node_count <= CNT_W'(1024);
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
      fill <= fill_next;
      if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
        node_count <= pwdata[CNT_W-1:0];
      end
      if (state == S_FIN && (!o_valid || rsp.ready)) begin
        o_valid <= 1'b1;
      end else if (rsp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_r_next;
    node_r <= node_r_next;
    w_r <= w_r_next;
    m_node <= m_node_next;
    m_w <= m_w_next;
    slot <= slot_next;
    res_status <= res_status_next;
    res_node <= res_node_next;
    res_prio <= res_prio_next;
    res_q <= res_q_next;
    if (state == S_FIN && (!o_valid || rsp.ready)) begin
      o_status <= res_status;
      o_node <= res_node;
      o_prio <= res_prio;
      o_q <= res_q;
      o_cnt <= CNT_W'(fill);
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.status = o_status;
  assign rsp.out_node = o_node;
  assign rsp.priority_res = o_prio;
  assign rsp.queued = o_q;
  assign rsp.entry_count = o_cnt;

endmodule
`default_nettype wire

// ===== design/imhpq_checker.sv =====
`default_nettype none
module imhpq_checker #(
  parameter int MAX_NODES   = 1024,
  parameter int WEIGHT_BITS = 32
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   valid,
  input wire logic                   ready,
  input wire logic [2:0]             status,
  input wire logic [9:0]             out_node,
  input wire logic [WEIGHT_BITS-1:0] priority_res,
  input wire logic                   queued,
  input wire logic [10:0]            entry_count
);
  import imhpq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(status) && $stable(out_node) &&
    $stable(priority_res) && $stable(entry_count))
    else $error("result item changed while stalled");

  a_range: assert property (@(posedge clk) disable iff (rst)
    valid && status == ST_RANGE |-> !queued && priority_res == '0)
    else $error("rejected node reported as queued");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    valid && status == ST_EMPTY |-> entry_count == '0 && out_node == '0 && !queued)
    else $error("empty pop with entries");

  a_count: assert property (@(posedge clk) disable iff (rst)
    valid |-> 32'(entry_count) <= MAX_NODES)
    else $error("entry count above capacity");

  a_queued: assert property (@(posedge clk) disable iff (rst)
    valid && (status == ST_QUEUED || status == ST_NOT_SMALLER) |->
    queued && entry_count != '0)
    else $error("queued node not reported as queued");

endmodule

bind indexed_min_heap_priority_queue_top imhpq_checker #(
  .MAX_NODES(MAX_NODES), .WEIGHT_BITS(WEIGHT_BITS)
) u_imhpq_checker (
  .clk(clk), .rst(rst), .valid(rsp.valid), .ready(rsp.ready), .status(rsp.status),
  .out_node(rsp.out_node), .priority_res(rsp.priority_res), .queued(rsp.queued),
  .entry_count(rsp.entry_count)
);
`default_nettype wire
